@@ rtl/core/deq_pkg.sv @@
// Shared types and constants for the double-ended queue.
`default_nettype none

package deq_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int ADDR_W        = 6;
   localparam int COUNT_W       = 7;
   localparam int VALUE_W       = 32;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_CLEAR      = 3'd4,
      OP_READ_ALL   = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_POP_EMPTY    = 2'd1,
      ST_PUSH_FULL    = 2'd2,
      ST_READ_REFUSED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      JOB_NONE  = 2'd0,
      JOB_WRITE = 2'd1,
      JOB_READ  = 2'd2,
      JOB_SCAN  = 2'd3
   } job_kind_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_SCAN = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [2:0]                opcode;
      logic signed [VALUE_W-1:0] push_value;
      logic [COUNT_W-1:0]        read_limit;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic [COUNT_W-1:0]        element_count;
      logic                      is_empty;
      status_type                status;
      logic                      last_of_run;
   } rsp_type;

   // Work handed from the front part to the back part.
   typedef struct packed {
      job_kind_type              kind;
      logic [ADDR_W-1:0]         addr;
      logic signed [VALUE_W-1:0] data;
      logic [COUNT_W-1:0]        count;
      status_type                status;
   } job_type;

   typedef struct packed {
      logic               use_rdata;
      logic [COUNT_W-1:0] count;
      status_type         status;
      logic               last;
   } meta_type;

endpackage

`default_nettype wire

@@ rtl/core/double_ended_queue.sv @@
// Top level: double-ended queue of signed words in a circular store.
// Push, pop, clear and refused commands each give their result from the back part's result
// registers once their job leaves the job queue; a read-all gives one element per cycle.
// Single-result commands are taken every cycle while busy is low; a read-all holds the
// store port to its last element; busy rises once the two-entry job queue before it is full.
// Synchronous reset empties the queue and clears both pointers; store contents are not cleared.
`default_nettype none

module double_ended_queue #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire deq_pkg::req_type req_item,
   output logic                  rsp_strobe,
   output deq_pkg::rsp_type      rsp_item
);

   logic             accept;
   logic             fifo_full;
   logic             fifo_empty;
   logic             fifo_pop;
   deq_pkg::job_type new_job;
   deq_pkg::job_type head_job;

   assign busy   = fifo_full;
   assign accept = start && !fifo_full;

   deq_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .job      (new_job)
   );

   deq_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_job (new_job),
      .pop      (fifo_pop),
      .head_job (head_job),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   deq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .fifo_empty (fifo_empty),
      .pop        (fifo_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

@@ rtl/core/deq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/deq_front.sv @@
// Front part: decodes commands, keeps pointers and count, and issues jobs.
`default_nettype none

module deq_front #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire deq_pkg::req_type req_item,
   output deq_pkg::job_type      job
);

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int JAW = deq_pkg::ADDR_W;
   localparam int JCW = deq_pkg::COUNT_W;

   logic [AW-1:0] front_ff, front_in;
   logic [AW-1:0] back_ff, back_in;
   logic [CW-1:0] count_ff, count_in;
   logic          is_full;
   logic          is_zero;
   logic [AW-1:0] front_dec, front_inc, back_dec, back_inc;

   always_comb begin
      front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
      front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);
      back_dec  = (back_ff == '0) ? AW'(DEPTH - 1) : back_ff - AW'(1);
      back_inc  = (back_ff == AW'(DEPTH - 1)) ? '0 : back_ff + AW'(1);
      is_full   = (count_ff == CW'(DEPTH));
      is_zero   = (count_ff == '0);
   end

   always_comb begin
      front_in   = front_ff;
      back_in    = back_ff;
      count_in   = count_ff;
      job.kind   = deq_pkg::JOB_NONE;
      job.addr   = '0;
      job.data   = req_item.push_value;
      job.status = deq_pkg::ST_OK;
      case (req_item.opcode)
         deq_pkg::OP_PUSH_FRONT: begin
            if (is_full) begin
               job.status = deq_pkg::ST_PUSH_FULL;
            end else begin
               job.kind = deq_pkg::JOB_WRITE;
               job.addr = JAW'(front_dec);
               front_in = front_dec;
               count_in = count_ff + CW'(1);
            end
         end
         deq_pkg::OP_PUSH_BACK: begin
            if (is_full) begin
               job.status = deq_pkg::ST_PUSH_FULL;
            end else begin
               job.kind = deq_pkg::JOB_WRITE;
               job.addr = JAW'(back_ff);
               back_in  = back_inc;
               count_in = count_ff + CW'(1);
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            if (is_zero) begin
               job.status = deq_pkg::ST_POP_EMPTY;
            end else begin
               job.kind = deq_pkg::JOB_READ;
               job.addr = JAW'(front_ff);
               front_in = front_inc;
               count_in = count_ff - CW'(1);
            end
         end
         deq_pkg::OP_POP_BACK: begin
            if (is_zero) begin
               job.status = deq_pkg::ST_POP_EMPTY;
            end else begin
               job.kind = deq_pkg::JOB_READ;
               job.addr = JAW'(back_dec);
               back_in  = back_dec;
               count_in = count_ff - CW'(1);
            end
         end
         deq_pkg::OP_CLEAR: begin
            front_in = '0;
            back_in  = '0;
            count_in = '0;
         end
         deq_pkg::OP_READ_ALL: begin
            if (JCW'(count_ff) > req_item.read_limit) begin
               job.status = deq_pkg::ST_READ_REFUSED;
            end else begin
               job.kind = deq_pkg::JOB_SCAN;
               job.addr = JAW'(front_ff);
            end
         end
         default: begin
         end
      endcase
      // For a read-all the count is unchanged and gives the number of elements.
      job.count = JCW'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count exceeds the store depth");

   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CW'(DEPTH)) |-> front_ff == back_ff)
      else $error("pointers disagree with an empty or full count");

endmodule

`default_nettype wire

@@ rtl/core/deq_fifo.sv @@
// Two-entry job queue between the front and back parts.
`default_nettype none

module deq_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire deq_pkg::job_type push_job,
   input  wire logic             pop,
   output deq_pkg::job_type      head_job,
   output logic                  full,
   output logic                  empty
);

   deq_pkg::job_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   always_comb begin
      full      = (fill_ff == 2'd2);
      empty     = (fill_ff == 2'd0);
      head_job  = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full) && !(pop && empty))
      else $error("job queue overrun or underrun");

endmodule

`default_nettype wire

@@ rtl/core/deq_back.sv @@
// Back part: carries out jobs on the entry store and produces the results.
`default_nettype none

module deq_back #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire deq_pkg::job_type head_job,
   input  wire logic             fifo_empty,
   output logic                  pop,
   output logic                  rsp_strobe,
   output deq_pkg::rsp_type      rsp_item
);

   localparam int AW  = $clog2(DEPTH);
   localparam int JCW = deq_pkg::COUNT_W;

   deq_pkg::back_state_type state_ff, state_in;
   logic [AW-1:0]           scan_addr_ff, scan_addr_in;
   logic [JCW-1:0]          remain_ff, remain_in;
   logic [JCW-1:0]          total_ff, total_in;
   logic                    out_valid_ff, out_valid_in;
   deq_pkg::meta_type       meta_ff, meta_in;
   logic                    wr_en;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [deq_pkg::VALUE_W-1:0] rd_data;

   deq_ram #(
      .WIDTH (deq_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (head_job.addr[AW-1:0]),
      .wr_data (head_job.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      scan_addr_in = scan_addr_ff;
      remain_in    = remain_ff;
      total_in     = total_ff;
      out_valid_in = 1'b0;
      meta_in      = meta_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = scan_addr_ff;
      case (state_ff)
         deq_pkg::BK_IDLE: begin
            if (!fifo_empty) begin
               pop               = 1'b1;
               meta_in.use_rdata = 1'b0;
               meta_in.count     = head_job.count;
               meta_in.status    = head_job.status;
               meta_in.last      = 1'b1;
               case (head_job.kind)
                  deq_pkg::JOB_WRITE: begin
                     wr_en        = 1'b1;
                     out_valid_in = 1'b1;
                  end
                  deq_pkg::JOB_READ: begin
                     rd_en             = 1'b1;
                     rd_addr           = head_job.addr[AW-1:0];
                     meta_in.use_rdata = 1'b1;
                     out_valid_in      = 1'b1;
                  end
                  deq_pkg::JOB_SCAN: begin
                     // An empty queue reads out nothing.
                     if (head_job.count != '0) begin
                        state_in     = deq_pkg::BK_SCAN;
                        scan_addr_in = head_job.addr[AW-1:0];
                        remain_in    = head_job.count;
                        total_in     = head_job.count;
                     end
                  end
                  default: begin
                     out_valid_in = 1'b1;
                  end
               endcase
            end
         end
         deq_pkg::BK_SCAN: begin
            rd_en             = 1'b1;
            out_valid_in      = 1'b1;
            meta_in.use_rdata = 1'b1;
            meta_in.count     = total_ff;
            meta_in.status    = deq_pkg::ST_OK;
            meta_in.last      = (remain_ff == JCW'(1));
            scan_addr_in      = (scan_addr_ff == AW'(DEPTH - 1)) ? '0
                                                                 : scan_addr_ff + AW'(1);
            remain_in         = remain_ff - JCW'(1);
            if (remain_ff == JCW'(1)) begin
               state_in = deq_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = deq_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
         remain_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         remain_ff    <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      total_ff     <= total_in;
      meta_ff      <= meta_in;
   end

   always_comb begin
      rsp_strobe             = out_valid_ff;
      rsp_item.out_value     = meta_ff.use_rdata ? rd_data : '0;
      rsp_item.element_count = meta_ff.count;
      rsp_item.is_empty      = (meta_ff.count == '0);
      rsp_item.status        = meta_ff.status;
      rsp_item.last_of_run   = meta_ff.last;
   end

   a_scan_remain: assert property (@(posedge clock) disable iff (reset)
      state_ff == deq_pkg::BK_SCAN |-> remain_ff != '0)
      else $error("readout running with nothing left to read");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && meta_ff.last) |-> state_ff == deq_pkg::BK_IDLE)
      else $error("last result given while a readout continues");

   a_run_mid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !meta_ff.last) |-> state_ff == deq_pkg::BK_SCAN)
      else $error("readout ended without a last result");

endmodule

`default_nettype wire
